FILE: hw/rtl/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// Shared constants and types of the count sketch engine: hash constants,
// counter limits, operation codes and the back-end status bundle.
// ----------------------------------------------------------------------------
package cse_pkg;

    // default geometry
    localparam int ROWS_DEF    = 3;
    localparam int BUCKETS_DEF = 65536;

    // work queue depth, also the most transactions in flight
    localparam int QDEPTH = 8;

    // murmur finalizer constants
    localparam logic [31:0] MIX_A     = 32'h85ebca6b;
    localparam logic [31:0] MIX_B     = 32'hc2b2ae35;
    localparam logic [31:0] HASH_MASK = 32'h7fffffff;

    // symmetric counter range
    localparam logic signed [31:0] CNT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] CNT_MIN = 32'sh80000001;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // back-end status seen by the front end
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_stat;

endpackage

FILE: hw/rtl/cse_ram.sv
// ----------------------------------------------------------------------------
// cse_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module cse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/cse_fifo.sv
// ----------------------------------------------------------------------------
// cse_fifo
// Small register queue between the hash front end and the counter back end.
// ----------------------------------------------------------------------------
module cse_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_pop,
    input  logic [WIDTH-1:0] i_din,
    output logic [WIDTH-1:0] o_dout,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wptr;
    logic [PW-1:0]    n_rptr;
    logic [CW-1:0]    n_count;

    // pointer and fill-level update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        n_count = r_count + CW'(i_push) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wptr] <= i_din;
        end
    end

    assign o_dout  = r_data[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));

endmodule

FILE: hw/rtl/cse_front.sv
// ----------------------------------------------------------------------------
// cse_front
// Accepts transactions, hashes the item for every row in a five-stage
// pipeline and pushes op, signs and bucket indexes into the work queue.
// ----------------------------------------------------------------------------
module cse_front #(
    parameter int ROWS    = cse_pkg::ROWS_DEF,
    parameter int BUCKETS = cse_pkg::BUCKETS_DEF,
    parameter int BW      = $clog2(BUCKETS),
    parameter int EW      = 1 + ROWS + ROWS * BW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_op,
    input  logic [31:0]           i_item,
    input  cse_pkg::t_back_stat   i_stat,
    output logic                  o_busy,
    output logic                  o_push,
    output logic [EW-1:0]         o_entry
);

    import cse_pkg::*;

    localparam int          NST   = 5;
    localparam int          CW    = $clog2(QDEPTH + 1);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / BUCKETS);

    logic [CW-1:0]   r_credit;
    logic [CW-1:0]   n_credit;
    logic            w_accept;
    logic [NST-1:0]  r_vld;
    logic            r_op [NST];
    logic [ROWS-1:0] r_sg [NST];

    // credit counts transactions in the pipeline and the queue
    assign o_busy   = i_stat.clearing || (r_credit == CW'(QDEPTH));
    assign w_accept = i_start && !o_busy;

    always_comb begin
        n_credit = r_credit + CW'(w_accept) - CW'(i_stat.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
            r_vld    <= '0;
        end else begin
            r_credit <= n_credit;
            r_vld    <= {r_vld[NST-2:0], w_accept};
        end
    end

    // op and sign bits travel with the hash
    always_ff @(posedge i_clk) begin
        r_op[0] <= i_op;
        r_sg[0] <= i_item[ROWS-1:0];
        for (int k = 1; k < NST; k++) begin
            r_op[k] <= r_op[k-1];
            r_sg[k] <= r_sg[k-1];
        end
    end

    assign o_push          = r_vld[NST-1];
    assign o_entry[0]      = r_op[NST-1];
    assign o_entry[ROWS:1] = r_sg[NST-1];

    // per-row hash lanes
    for (genvar g = 0; g < ROWS; g++) begin : g_lane
        logic [31:0] r_m1;
        logic [31:0] r_p2;
        logic [31:0] r_p3;
        logic [30:0] r_q4;
        logic [30:0] r_h4;
        logic [30:0] r_h5;
        logic [30:0] r_qb5;
        logic [31:0] w_a;
        logic [31:0] w_b;
        logic [30:0] w_h;
        logic [63:0] w_qfull;
        logic [30:0] w_rem;
        logic [30:0] w_red;

        // finalizer mixing steps
        assign w_a     = r_m1 ^ (r_m1 >> 16);
        assign w_b     = r_p2 ^ (r_p2 >> 13);
        assign w_h     = 31'((r_p3 ^ (r_p3 >> 16)) & HASH_MASK);
        // quotient estimate by reciprocal, at most one short
        assign w_qfull = {33'd0, w_h} * {32'd0, RECIP};
        // remainder with one correction step
        assign w_rem   = r_h5 - r_qb5;
        assign w_red   = (w_rem >= 31'(BUCKETS)) ? w_rem - 31'(BUCKETS) : w_rem;

        always_ff @(posedge i_clk) begin
            r_m1  <= 32'(i_item * 32'(g + 1));
            r_p2  <= 32'(w_a * MIX_A);
            r_p3  <= 32'(w_b * MIX_B);
            r_h4  <= w_h;
            r_q4  <= w_qfull[62:32];
            r_h5  <= r_h4;
            r_qb5 <= 31'(r_q4 * 31'(BUCKETS));
        end

        assign o_entry[ROWS + 1 + g * BW +: BW] = w_red[BW-1:0];
    end

endmodule

FILE: hw/rtl/cse_back.sv
// ----------------------------------------------------------------------------
// cse_back
// Pops work from the queue, reads each row's counter, writes back the
// saturated update for an insert or forms the median estimate for a query.
// Runs the clearing pass over the counter RAMs after reset.
// ----------------------------------------------------------------------------
module cse_back #(
    parameter int ROWS    = cse_pkg::ROWS_DEF,
    parameter int BUCKETS = cse_pkg::BUCKETS_DEF,
    parameter int BW      = $clog2(BUCKETS),
    parameter int EW      = 1 + ROWS + ROWS * BW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  logic [EW-1:0]         i_entry,
    output cse_pkg::t_back_stat   o_stat,
    output logic                  o_valid,
    output logic [30:0]           o_estimate
);

    import cse_pkg::*;

    localparam int RKW = $clog2(ROWS + 1);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_DATA = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_SEL  = 3'd4;

    logic [2:0]         r_state;
    logic [BW-1:0]      r_clr_addr;
    logic               r_op;
    logic [ROWS-1:0]    r_sg;
    logic [BW-1:0]      r_bkt   [ROWS];
    logic signed [31:0] r_val   [ROWS];
    logic [ROWS-1:0]    r_lt    [ROWS];
    logic               r_out_vld;
    logic [30:0]        r_est;

    logic [BW-1:0]      w_head  [ROWS];
    logic [BW-1:0]      w_addr  [ROWS];
    logic [ROWS-1:0]    w_we;
    logic [31:0]        w_wdata [ROWS];
    logic [31:0]        w_rdata [ROWS];
    logic signed [31:0] w_sat   [ROWS];
    logic signed [31:0] w_sval  [ROWS];
    logic [RKW-1:0]     w_rank  [ROWS];
    logic signed [31:0] w_med;

    // status toward the front end
    assign o_stat.pop      = (r_state == ST_IDLE) && !i_empty;
    assign o_stat.clearing = (r_state == ST_CLR);

    // counter RAM per row
    for (genvar g = 0; g < ROWS; g++) begin : g_row
        cse_ram #(
            .WIDTH (32),
            .DEPTH (BUCKETS),
            .AW    (BW)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we[g]),
            .i_addr  (w_addr[g]),
            .i_wdata (w_wdata[g]),
            .o_rdata (w_rdata[g])
        );
    end

    // saturating update and signed counter per row
    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            w_head[r] = i_entry[ROWS + 1 + r * BW +: BW];
            if (r_sg[r]) begin
                w_sat[r]  = ($signed(w_rdata[r]) <= CNT_MIN) ? $signed(w_rdata[r])
                                                             : $signed(w_rdata[r]) - 32'sd1;
                w_sval[r] = -$signed(w_rdata[r]);
            end else begin
                w_sat[r]  = ($signed(w_rdata[r]) >= CNT_MAX) ? $signed(w_rdata[r])
                                                             : $signed(w_rdata[r]) + 32'sd1;
                w_sval[r] = $signed(w_rdata[r]);
            end
        end
    end

    // RAM address and write control
    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            w_addr[r]  = r_clr_addr;
            w_wdata[r] = '0;
            w_we[r]    = 1'b0;
            case (r_state)
                ST_CLR: begin
                    w_we[r] = 1'b1;
                end
                ST_IDLE: begin
                    w_addr[r] = w_head[r];
                end
                ST_DATA: begin
                    w_addr[r]  = r_bkt[r];
                    w_wdata[r] = w_sat[r];
                    w_we[r]    = (r_op == OP_INSERT);
                end
                default: begin
                    w_addr[r] = r_clr_addr;
                end
            endcase
        end
    end

    // rank of each signed counter, ties broken by row order; the middle rank is the median
    always_comb begin
        w_med = '0;
        for (int i = 0; i < ROWS; i++) begin
            w_rank[i] = '0;
            for (int j = 0; j < ROWS; j++) begin
                w_rank[i] = w_rank[i] + RKW'(r_lt[i][j]);
            end
            if (w_rank[i] == RKW'(ROWS / 2)) begin
                w_med = r_val[i];
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_clr_addr <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;
            case (r_state)
                ST_CLR: begin
                    if (r_clr_addr == BW'(BUCKETS - 1)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_op    <= i_entry[0];
                        r_sg    <= i_entry[ROWS:1];
                        r_bkt   <= w_head;
                        r_state <= ST_DATA;
                    end
                end
                ST_DATA: begin
                    r_val <= w_sval;
                    if (r_op == OP_INSERT) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    for (int i = 0; i < ROWS; i++) begin
                        for (int j = 0; j < ROWS; j++) begin
                            r_lt[i][j] <= (r_val[j] < r_val[i])
                                       || ((r_val[j] == r_val[i]) && (j < i));
                        end
                    end
                    r_state <= ST_SEL;
                end
                ST_SEL: begin
                    r_out_vld <= 1'b1;
                    r_est     <= w_med[31] ? '0 : w_med[30:0];
                    r_state   <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid    = r_out_vld;
    assign o_estimate = r_est;

endmodule

FILE: hw/rtl/count_sketch_engine.sv
// ----------------------------------------------------------------------------
// count_sketch_engine
// Count sketch over ROWS rows of BUCKETS saturating signed counters, with
// insert and median-estimate query transactions.
// ----------------------------------------------------------------------------
// After reset the block clears its counter RAMs, one bucket of every row per
// cycle, over all BUCKETS buckets (65536 by default), while busy stays high. A
// transaction is taken when start is high and busy is low. The front end
// hashes it in its pipeline and queues it; busy rises when eight transactions
// are in flight. The back end has one RAM port per row, so an insert holds it
// to read the counters and write them back, and a query to read, compare and
// select; the back end pops no new entry until it is done with the last. A
// query's estimate appears on o_estimate with o_valid high for exactly one
// cycle and must be captured then; inserts give no result.
// ----------------------------------------------------------------------------
module count_sketch_engine #(
    parameter int ROWS    = cse_pkg::ROWS_DEF,
    parameter int BUCKETS = cse_pkg::BUCKETS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [31:0] i_item,
    output logic        o_valid,
    output logic [30:0] o_estimate
);

    import cse_pkg::*;

    localparam int BW = $clog2(BUCKETS);
    localparam int EW = 1 + ROWS + ROWS * BW;

    t_back_stat    w_stat;
    logic          w_push;
    logic [EW-1:0] w_push_entry;
    logic [EW-1:0] w_head_entry;
    logic          w_empty;
    logic          w_full;

    // hash front end
    cse_front #(
        .ROWS    (ROWS),
        .BUCKETS (BUCKETS),
        .BW      (BW),
        .EW      (EW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .i_item  (i_item),
        .i_stat  (w_stat),
        .o_busy  (busy),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    // work queue
    cse_fifo #(
        .WIDTH (EW),
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_stat.pop),
        .i_din   (w_push_entry),
        .o_dout  (w_head_entry),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // counter back end
    cse_back #(
        .ROWS    (ROWS),
        .BUCKETS (BUCKETS),
        .BW      (BW),
        .EW      (EW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_entry    (w_head_entry),
        .o_stat     (w_stat),
        .o_valid    (o_valid),
        .o_estimate (o_estimate)
    );

    // credit keeps the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("work queue pushed while full");

    // back end pops only real work
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.pop |-> !w_empty)
        else $error("work queue popped while empty");

    // the result strobe is never high in consecutive cycles
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // nothing comes out or queues up during the clearing pass
    a_quiet_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.clearing |-> (!o_valid && w_empty))
        else $error("activity during clearing pass");

endmodule
